// ===== rtl/fletcher_byte_checksum_defines.svh =====
// fletcher_byte_checksum_defines.svh: assertion macros for the checksum block
// used by the port checker; no other dependencies
`ifndef FLETCHER_BYTE_CHECKSUM_DEFINES_SVH
`define FLETCHER_BYTE_CHECKSUM_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fbc check failed");

// next-cycle implication, masked while reset is asserted
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fbc check failed");

// next-cycle implication that also covers the reset cycles
`define FBC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fbc check failed");

`endif

// ===== rtl/fbc_pkg.sv =====
// fbc_pkg: widths, constants, fold functions and the fold request type
// for the byte checksum block; no dependencies
`default_nettype none

package fbc_pkg;

    localparam int FOLD_INTERVAL = 360;
    localparam int CNT_W         = $clog2(FOLD_INTERVAL + 1);
    localparam int LOW_W         = 18;
    localparam int HIGH_W        = 26;
    localparam int HALF_W        = 16;
    localparam int FOLD_W        = HALF_W + 1;
    localparam int BYTE_W        = 8;
    localparam int CSUM_W        = 2 * HALF_W;

    localparam logic [HALF_W-1:0] SUM_RESET = 16'hFFFF;

    // once-folded sums handed to the output stage
    typedef struct packed {
        logic [FOLD_W-1:0] low;
        logic [FOLD_W-1:0] high;
    } t_fold_req;

    // low half plus the part above it, for a running sum
    function automatic logic [FOLD_W-1:0] fold_wide(input logic [HIGH_W-1:0] v);
        return {1'b0, v[HALF_W-1:0]}
             + {{(FOLD_W-(HIGH_W-HALF_W)){1'b0}}, v[HIGH_W-1:HALF_W]};
    endfunction

    // second fold of an already folded sum, kept to the low half
    function automatic logic [HALF_W-1:0] fold_narrow(input logic [FOLD_W-1:0] v);
        return v[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, v[FOLD_W-1]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fbc_out_stage.sv =====
// fbc_out_stage: final fold of both sums and the registered checksum output
// depends on fbc_pkg
`default_nettype none

module fbc_out_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    input  wire fbc_pkg::t_fold_req        i_req,
    output logic                           o_ready,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [fbc_pkg::CSUM_W-1:0]     o_checksum
);

    logic                          r_valid;
    logic [fbc_pkg::CSUM_W-1:0]    r_checksum;
    logic [fbc_pkg::CSUM_W-1:0]    n_checksum;

    // register can take a new request when empty or being drained
    assign o_ready = !r_valid || !i_stall;

    // second fold: second sum on top, first sum below
    assign n_checksum = {fbc_pkg::fold_narrow(i_req.high), fbc_pkg::fold_narrow(i_req.low)};

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_req_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_req_valid) begin
            r_checksum <= n_checksum;
        end
    end

    assign o_valid    = r_valid;
    assign o_checksum = r_checksum;

endmodule

`default_nettype wire

// ===== rtl/fletcher_byte_checksum.sv =====
// fletcher_byte_checksum: Fletcher-32 style checksum over a byte stream
// depends on fbc_pkg and fbc_out_stage
//
// Input channel: one message byte per request (i_byte_value) with
// i_last_byte marking the final byte; taken when i_valid is high and
// o_stall is low. Output channel: one 32-bit checksum per message
// (second sum in bits 31..16, first sum in bits 15..0), taken when
// o_valid is high and i_stall is low.
// Throughput: one byte per cycle while o_stall is low. The running sums
// update in the cycle a byte is taken (byte add, second-sum add and
// optional fold in one pass). After the last byte is taken, its checksum
// passes the fold register and then the output register to o_valid.
// When the receiver stalls, the output holds and one more finished
// message can wait in the fold register; while that register is full
// and the output is still stalled, o_stall is high and no byte of any
// kind is taken until the receiver drains the output.
// Reset: synchronous, active low; the sums return to 0xFFFF, the byte
// count to zero and both output-side registers empty.
`default_nettype none

module fletcher_byte_checksum (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [fbc_pkg::BYTE_W-1:0]  i_byte_value,
    input  wire logic                        i_last_byte,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [fbc_pkg::CSUM_W-1:0]       o_checksum
);

    logic [fbc_pkg::LOW_W-1:0]    r_low_sum;
    logic [fbc_pkg::HIGH_W-1:0]   r_high_sum;
    logic [fbc_pkg::CNT_W-1:0]    r_block_count;
    logic [fbc_pkg::LOW_W-1:0]    n_low_sum;
    logic [fbc_pkg::HIGH_W-1:0]   n_high_sum;
    logic [fbc_pkg::CNT_W-1:0]    n_block_count;

    logic                         r_fold_valid;
    fbc_pkg::t_fold_req           r_fold;

    logic [fbc_pkg::LOW_W-1:0]    sum1;
    logic [fbc_pkg::HIGH_W-1:0]   sum2;
    logic [fbc_pkg::FOLD_W-1:0]   fold1;
    logic [fbc_pkg::FOLD_W-1:0]   fold2;
    logic                         do_fold;
    logic                         accept;
    logic                         out_ready;
    logic                         fold_ready;

    // handshake
    assign fold_ready = !r_fold_valid || out_ready;
    assign o_stall    = !fold_ready;
    assign accept     = i_valid && !o_stall;

    // running sums and fold decision
    always_comb begin
        sum1 = r_low_sum + {{(fbc_pkg::LOW_W-fbc_pkg::BYTE_W){1'b0}}, i_byte_value};
        sum2 = r_high_sum + {{(fbc_pkg::HIGH_W-fbc_pkg::LOW_W){1'b0}}, sum1};
        n_block_count = r_block_count + {{(fbc_pkg::CNT_W-1){1'b0}}, 1'b1};
        do_fold = (n_block_count >= fbc_pkg::CNT_W'(fbc_pkg::FOLD_INTERVAL)) || i_last_byte;
        fold1 = fbc_pkg::fold_wide({{(fbc_pkg::HIGH_W-fbc_pkg::LOW_W){1'b0}}, sum1});
        fold2 = fbc_pkg::fold_wide(sum2);
        n_low_sum  = sum1;
        n_high_sum = sum2;
        if (i_last_byte) begin
            n_low_sum     = {{(fbc_pkg::LOW_W-fbc_pkg::HALF_W){1'b0}}, fbc_pkg::SUM_RESET};
            n_high_sum    = {{(fbc_pkg::HIGH_W-fbc_pkg::HALF_W){1'b0}}, fbc_pkg::SUM_RESET};
            n_block_count = '0;
        end else if (do_fold) begin
            n_low_sum     = {{(fbc_pkg::LOW_W-fbc_pkg::FOLD_W){1'b0}}, fold1};
            n_high_sum    = {{(fbc_pkg::HIGH_W-fbc_pkg::FOLD_W){1'b0}}, fold2};
            n_block_count = '0;
        end
    end

    // sum state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_sum     <= {{(fbc_pkg::LOW_W-fbc_pkg::HALF_W){1'b0}}, fbc_pkg::SUM_RESET};
            r_high_sum    <= {{(fbc_pkg::HIGH_W-fbc_pkg::HALF_W){1'b0}}, fbc_pkg::SUM_RESET};
            r_block_count <= '0;
        end else if (accept) begin
            r_low_sum     <= n_low_sum;
            r_high_sum    <= n_high_sum;
            r_block_count <= n_block_count;
        end
    end

    // fold register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
        end else if (fold_ready) begin
            r_fold_valid <= accept && i_last_byte;
        end
    end

    // fold register payload: once-folded sums of a finished message
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_fold.low  <= fold1;
            r_fold.high <= fold2;
        end
    end

    // second fold and output register
    fbc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_fold_valid),
        .i_req       (r_fold),
        .o_ready     (out_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_checksum  (o_checksum)
    );

endmodule

`default_nettype wire

// ===== rtl/fbc_checker.sv =====
// fbc_checker: port-level checks on the checksum block, bound to the top
// depends on fletcher_byte_checksum_defines.svh and fbc_pkg
`default_nettype none

`include "fletcher_byte_checksum_defines.svh"

module fbc_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        o_stall,
    input  wire logic [fbc_pkg::BYTE_W-1:0]  i_byte_value,
    input  wire logic                        i_last_byte,
    input  wire logic                        o_valid,
    input  wire logic                        i_stall,
    input  wire logic [fbc_pkg::CSUM_W-1:0]  o_checksum
);

    logic in_take;
    logic last_take;

    assign in_take   = i_valid && !o_stall;
    assign last_take = in_take && i_last_byte && (i_byte_value == i_byte_value);

    // a stalled result holds
    `FBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_checksum))

    // output is empty after reset
    `FBC_ASSERT_NEXT_ALWAYS(a_out_reset, i_clk, !i_rst_n, !o_valid)

    // input stalls only when a result waits on a stalled receiver
    `FBC_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // a new result follows a last byte taken, via the fold and output registers
    `FBC_ASSERT_SAME(a_out_origin, i_clk, i_rst_n, $rose(o_valid), $past(last_take, 2) && $past(i_rst_n, 2))

endmodule

bind fletcher_byte_checksum fbc_checker u_fbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_byte_value (i_byte_value),
    .i_last_byte  (i_last_byte),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_checksum   (o_checksum)
);

`default_nettype wire
